/* hdl/bfdt_pkg.sv */
// Shared types and constants of the blocking flow shop departure time unit.
`default_nettype none

package bfdt_pkg;

	// Fixed field widths
	localparam int unsigned PROC_W     = 16;
	localparam int unsigned CFG_W      = 5;
	localparam int unsigned CFG_RESET  = 2;
	localparam int unsigned OUT_TIME_W = 32;
	localparam int unsigned IDX_W      = 4;

	typedef logic [OUT_TIME_W-1:0] out_time_t;
	typedef logic [IDX_W-1:0]      mach_idx_t;
	typedef logic [CFG_W-1:0]      cfg_word_t;

	// One input beat
	typedef struct packed {
		logic [PROC_W-1:0] proc_time;
		logic              new_sequence;
	} in_item_t;

	// One result beat
	typedef struct packed {
		out_time_t departure_time;
		mach_idx_t machine_index;
		logic      last_machine;
		out_time_t idle_block_sum;
	} result_t;

endpackage

`default_nettype wire

/* hdl/bfdt_in_stage.sv */
// Input register stage: holds one accepted beat until the core takes it.
`default_nettype none

module bfdt_in_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [15:0]        s_tdata,      // [15:0] proc_time
	input  wire logic               s_tuser,      // [0] new_sequence
	output logic                    item_valid,
	output bfdt_pkg::in_item_t      item,
	input  wire logic               item_take
);

	logic               valid_q;
	bfdt_pkg::in_item_t item_q;

	// Accept when empty or when the held beat leaves this cycle
	assign s_tready   = !valid_q || item_take;
	assign item_valid = valid_q;
	assign item       = item_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_q <= 1'b1;
		end else if (item_take) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the beat
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q.proc_time    <= s_tdata;
			item_q.new_sequence <= s_tuser;
		end
	end

endmodule

`default_nettype wire

/* hdl/bfdt_core.sv */
// Departure time recurrence, row store and sigma accumulation.
`default_nettype none

module bfdt_core #(
	parameter int MAX_MACHINES = 16,
	parameter int TIME_WIDTH   = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire bfdt_pkg::cfg_word_t cfg_data,
	input  wire logic                item_valid,
	input  wire bfdt_pkg::in_item_t  item,
	output logic                     item_take,
	input  wire logic                res_ready,
	output logic                     res_valid,
	output bfdt_pkg::result_t        res
);

	localparam int CW = $clog2(MAX_MACHINES);
	localparam int MW = (CW + 1 > int'(bfdt_pkg::CFG_W)) ? CW + 1 : int'(bfdt_pkg::CFG_W);
	localparam int TW = TIME_WIDTH;

	typedef logic [TW-1:0] time_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic [MW-1:0] mcnt_t;

	function automatic time_t sat_add(input time_t a, input time_t b);
		logic [TW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TW] ? '1 : s[TW-1:0];
	endfunction

	// Configuration and job state
	bfdt_pkg::cfg_word_t mcount_q;
	cnt_t                cnt_q;
	time_t               left_q;
	time_t               sig_q;
	logic                first_q;

	// Previous row: entries 0 and 1 in flops, all entries in the memory
	time_t               mem [MAX_MACHINES];
	time_t               mem_rd_q;
	time_t               row0_q;
	time_t               row1_q;
	time_t               cur_q;
	time_t               nxt_q;
	logic                nxt_mem_q;

	// Datapath
	logic                fire;
	logic                first;
	cnt_t                j;
	cnt_t                j_plus2;
	time_t               left;
	time_t               sig;
	time_t               p_ext;
	mcnt_t               mc_ext;
	mcnt_t               m_eff;
	logic                last;
	time_t               prev_j;
	time_t               prev_j1;
	time_t               own;
	time_t               dep;
	time_t               base;
	logic [TW:0]         bp;
	time_t               diff;
	time_t               term;
	time_t               sig_new;

	assign cfg_ready = 1'b1;
	assign fire      = item_valid && res_ready;
	assign item_take = fire;
	assign res_valid = fire;

	// Clamp the machine count to the supported range
	always_comb begin
		mc_ext = mcnt_t'(mcount_q);
		m_eff  = mc_ext;
		if (mc_ext < mcnt_t'(2)) begin
			m_eff = mcnt_t'(2);
		end else if (mc_ext > mcnt_t'(MAX_MACHINES)) begin
			m_eff = mcnt_t'(MAX_MACHINES);
		end
	end

	// A new sequence restarts at machine 0 of a first job
	assign first   = item.new_sequence || first_q;
	assign j       = item.new_sequence ? '0 : cnt_q;
	assign left    = item.new_sequence ? '0 : left_q;
	assign sig     = item.new_sequence ? '0 : sig_q;
	assign j_plus2 = j + cnt_t'(2);
	assign last    = mcnt_t'(j) >= (m_eff - mcnt_t'(1));
	assign p_ext   = time_t'(item.proc_time);
	assign prev_j  = cur_q;
	assign prev_j1 = nxt_mem_q ? mem_rd_q : nxt_q;

	// Own completion, then blocking by the downstream machine
	assign own = sat_add((!first && j == '0) ? prev_j : left, p_ext);
	assign dep = (first || last) ? own : ((own > prev_j1) ? own : prev_j1);

	// Sigma term: dep - prev - p, clamped at zero
	assign base    = first ? '0 : prev_j;
	assign bp      = {1'b0, base} + {1'b0, p_ext};
	assign diff    = dep - bp[TW-1:0];
	assign term    = ({1'b0, dep} >= bp) ? diff : '0;
	assign sig_new = sat_add(sig, term);

	// Result beat
	always_comb begin
		res.departure_time = bfdt_pkg::out_time_t'(dep);
		res.machine_index  = bfdt_pkg::mach_idx_t'(j);
		res.last_machine   = last;
		res.idle_block_sum = last ? bfdt_pkg::out_time_t'(sig_new) : '0;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcount_q <= bfdt_pkg::cfg_word_t'(bfdt_pkg::CFG_RESET);
		end else if (cfg_valid && cfg_ready) begin
			mcount_q <= cfg_data;
		end
	end

	// Advance the job state per item; wrap at the last machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			left_q    <= '0;
			sig_q     <= '0;
			first_q   <= 1'b1;
			nxt_mem_q <= 1'b0;
		end else if (fire) begin
			nxt_mem_q <= !last;
			if (last) begin
				cnt_q   <= '0;
				left_q  <= '0;
				sig_q   <= '0;
				first_q <= 1'b0;
			end else begin
				cnt_q   <= j + cnt_t'(1);
				left_q  <= dep;
				sig_q   <= sig_new;
				first_q <= first;
			end
		end
	end

	// Write the row in place and prefetch the entry two machines ahead
	always_ff @(posedge clk) begin
		if (fire) begin
			mem[j]   <= dep;
			mem_rd_q <= mem[j_plus2];
		end
	end

	// Hold the row head in flops so a wrap needs no memory read
	always_ff @(posedge clk) begin
		if (fire) begin
			if (j == '0) begin
				row0_q <= dep;
			end
			if (j == cnt_t'(1)) begin
				row1_q <= dep;
			end
			if (last) begin
				cur_q <= row0_q;
				nxt_q <= (j == cnt_t'(1)) ? dep : row1_q;
			end else begin
				cur_q <= prev_j1;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/bfdt_out_stage.sv */
// Result register stage driving the master-side stream.
`default_nettype none

module bfdt_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_valid,
	output logic                   res_ready,
	input  wire bfdt_pkg::result_t res,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [63:0]            m_tdata,   // [31:0] departure_time, [63:32] idle_block_sum
	output logic                   m_tlast,   // last_machine
	output logic [3:0]             m_tuser    // [3:0] machine_index
);

	logic              valid_q;
	bfdt_pkg::result_t res_q;

	// Take a new result when empty or when the held one is taken
	assign res_ready = !valid_q || m_tready;
	assign m_tvalid  = valid_q;
	assign m_tdata   = {res_q.idle_block_sum, res_q.departure_time};
	assign m_tlast   = res_q.last_machine;
	assign m_tuser   = res_q.machine_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

/* hdl/blocking_flowshop_departure_times_unit.sv */
// Top level of the blocking flow shop departure time unit.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_data write the machine count (2..MAX_MACHINES);
//   cfg_ready is always high. Write it only while no beat is in flight.
//   The slave stream carries one processing time per beat, machine 0 first,
//   job after job; s_tuser marks machine 0 of a sequence's first job.
//   The master stream returns one departure time per input beat with its
//   machine index in m_tuser; m_tlast marks the job's last machine, and
//   only then m_tdata[63:32] carries the job's idle-and-blocking sum.
// Timing:
//   A beat goes from the input register through the core to the result
//   register. Throughput is one beat per cycle unless the receiver stalls,
//   set by the recurrence through the row store prefetch register.
// Reset and stall:
//   Reset clears the job state and returns the machine count to two; the
//   row store holds no valid data until the first job is run. When the
//   receiver stalls, the result holds and s_tready drops in the same cycle
//   while the input register holds a beat; an empty one still takes one more.
`default_nettype none

module blocking_flowshop_departure_times_unit #(
	parameter int MAX_MACHINES = 16,
	parameter int TIME_WIDTH   = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  cfg_data,    // machine_count
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,     // [15:0] proc_time
	input  wire logic        s_tuser,     // [0] new_sequence
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,     // [31:0] departure_time, [63:32] idle_block_sum
	output logic             m_tlast,     // last_machine
	output logic [3:0]       m_tuser      // [3:0] machine_index
);

	logic               item_valid;
	bfdt_pkg::in_item_t item;
	logic               item_take;
	logic               res_valid;
	logic               res_ready;
	bfdt_pkg::result_t  res;

	bfdt_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	bfdt_core #(
		.MAX_MACHINES (MAX_MACHINES),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.res        (res)
	);

	bfdt_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

/* hdl/bfdt_checker.sv */
// Port-level checks of the departure time unit and their binding.
`default_nettype none

module bfdt_checker #(
	parameter int MAX_MACHINES = 16
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic [3:0]  m_tuser
);

	// Hold a stalled result beat
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Sigma only rides on the last machine
	a_sigma_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[63:32] == 32'd0)
		else $error("sigma nonzero on a middle machine");

	// Machine 0 is never the last machine
	a_last_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (MAX_MACHINES > 16) || (m_tuser != 4'd0))
		else $error("last machine flagged on machine 0");

	// No result beat right after arst_n is sampled low
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result beat after reset");

endmodule

bind blocking_flowshop_departure_times_unit bfdt_checker #(
	.MAX_MACHINES (MAX_MACHINES)
) u_bfdt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire
